/* rtl/core/dsba_pkg.sv */
`default_nettype none
package dsba_pkg;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOEXPAND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    // Request function codes
    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_RESIZE = 1'b1;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;      // latch request, classify
        logic scan;      // compare one record against the request
        logic lowest;    // apply lowest-block update
        logic shrink;    // apply non-lowest shrink (at found slot)
        logic pop;       // pop one record if unused
        logic finish;    // fix bottom on empty table
    } dsba_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic is_new;        // new-block request
        logic new_ok;        // new block allowed
        logic new_full;      // table full
        logic is_bottom;     // resize of the lowest block
        logic scan_done;     // scan reached end
        logic scan_hit;      // current record matches
        logic pop_more;      // top record unused and table not empty
    } dsba_stat_t;

endpackage
`default_nettype wire

/* rtl/core/dsba_datapath.sv */
`default_nettype none
module dsba_datapath
    import dsba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int ALIGN_BYTES  = 4096,
    parameter int HEADER_BYTES = 8,
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CW = $clog2(MAX_BLOCKS + 1)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    output logic [31:0]      top_address,
    input  wire dsba_cmd_t   cmd,
    output dsba_stat_t       stat,
    output logic             fits,
    input  wire logic        in_func,
    input  wire logic [31:0] in_addr,
    input  wire logic [31:0] in_size,
    output logic [31:0]      res_address,
    output logic [1:0]       res_status,
    output logic [31:0]      res_msrc,
    output logic [31:0]      res_mdst,
    output logic [31:0]      res_mlen,
    output logic [31:0]      res_hidden,
    input  wire logic [1:0]  set_status
);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [31:0] AMASK = 32'(ALIGN_BYTES - 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    logic [31:0]   start_mem [MAX_BLOCKS];
    logic [31:0]   size_mem  [MAX_BLOCKS];
    logic          used_mem  [MAX_BLOCKS];

    logic [31:0]   top_reg, bottom_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   addr_reg, req_reg;
    logic          new_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   res_addr_reg, msrc_reg, mdst_reg, mlen_reg;
    logic [1:0]    status_reg;

    assign top_address = top_reg;

    // Request classification
    logic          is_new_c;
    assign is_new_c = (in_func == FUNC_ALLOC) || (in_addr == '0) || (in_addr == ALL_ONES);

    logic [IW-1:0] idx;
    logic [IW-1:0] last;
    assign idx  = idx_reg[IW-1:0];
    assign last = IW'(count_reg - CW'(1));

    // Lowest-block arithmetic
    logic [31:0] ptr, old, d, nstart, pad, fsize32;
    logic        ok, carry;
    always_comb
    begin
        ptr = new_reg ? (bottom_reg - HDR) : addr_reg;
        old = new_reg ? '0 : size_mem[last];
        d   = req_reg - old;
        if (req_reg >= old)
            nstart = ptr - d;
        else
            nstart = ptr + (old - req_reg);
        pad = nstart & AMASK;
        {carry, fsize32} = {1'b0, req_reg} + {1'b0, pad};
        ok = !((req_reg >= old) && (d > ptr)) && !carry;
    end

    always_comb
    begin
        stat.is_new    = new_reg;
        stat.new_full  = count_reg >= MAXC;
        stat.new_ok    = (count_reg < MAXC) && (bottom_reg >= HDR);
        stat.is_bottom = (count_reg != '0) && (addr_reg == bottom_reg);
        stat.scan_done = (idx_reg + CW'(1)) >= count_reg;
        stat.scan_hit  = start_mem[idx] == addr_reg;
        stat.pop_more  = (count_reg != '0) && !used_mem[last];
    end

    // Found record may only shrink
    assign fits = req_reg <= size_mem[idx];

    // Record table
    always_ff @(posedge clk)
    begin
        if (cmd.lowest && ok)
        begin
            start_mem[new_reg ? IW'(count_reg) : last] <= nstart - pad;
            size_mem[new_reg ? IW'(count_reg) : last]  <= fsize32;
            used_mem[new_reg ? IW'(count_reg) : last]  <= req_reg != '0;
        end
        else if (cmd.shrink)
            used_mem[idx] <= req_reg != '0;
    end

    // Control state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= 32'd655360;
            bottom_reg <= 32'd655360;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                top_reg <= cfg_data;
                if (count_reg == '0)
                    bottom_reg <= cfg_data;
            end
            else if (cmd.lowest && ok)
            begin
                bottom_reg <= nstart - pad;
                if (new_reg)
                    count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop && stat.pop_more)
            begin
                bottom_reg <= start_mem[last] + size_mem[last] + HDR;
                count_reg  <= count_reg - CW'(1);
            end
            else if (cmd.finish && count_reg == '0)
                bottom_reg <= top_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg     <= in_addr;
            req_reg      <= in_size;
            new_reg      <= is_new_c;
            idx_reg      <= '0;
            res_addr_reg <= '0;
            msrc_reg     <= '0;
            mdst_reg     <= '0;
            mlen_reg     <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (cmd.scan)
                idx_reg <= idx_reg + CW'(1);
            if (set_status != ST_OK)
                status_reg <= set_status;
            if (cmd.lowest)
            begin
                if (ok)
                begin
                    res_addr_reg <= (fsize32 != '0) ? (nstart - pad) : ALL_ONES;
                    mlen_reg <= (old < fsize32) ? old : fsize32;
                    if (((old < fsize32) ? old : fsize32) != '0)
                    begin
                        msrc_reg <= ptr;
                        mdst_reg <= nstart - pad;
                    end
                end
                else
                    status_reg <= ST_NOEXPAND;
            end
            if (cmd.shrink)
                res_addr_reg <= (req_reg != '0) ? addr_reg : ALL_ONES;
        end
    end

    assign res_address = res_addr_reg;
    assign res_status  = status_reg;
    assign res_msrc    = msrc_reg;
    assign res_mdst    = mdst_reg;
    assign res_mlen    = mlen_reg;
    assign res_hidden  = bottom_reg - HDR;
endmodule
`default_nettype wire

/* rtl/core/dsba_ctrl.sv */
`default_nettype none
module dsba_ctrl
    import dsba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire logic       fits,
    input  wire dsba_stat_t stat,
    output dsba_cmd_t       cmd,
    output logic [1:0]      set_status
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_LOW    = 7'b0001000,
        S_POP    = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        set_status = ST_OK;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.is_new)
                begin
                    if (stat.new_full)
                    begin
                        set_status = ST_FULL;
                        state_next = S_FIN;
                    end
                    else if (!stat.new_ok)
                    begin
                        set_status = ST_NOEXPAND;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_LOW;
                end
                else if (stat.is_bottom)
                    state_next = S_LOW;
                else if (stat.scan_done)
                begin
                    set_status = ST_UNKNOWN;
                    state_next = S_FIN;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    if (fits)
                    begin
                        cmd.shrink = 1'b1;
                        state_next = S_POP;
                    end
                    else
                    begin
                        set_status = ST_NOEXPAND;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (stat.scan_done)
                    begin
                        set_status = ST_UNKNOWN;
                        state_next = S_FIN;
                    end
                end
            end
            S_LOW:
            begin
                cmd.lowest = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (!stat.pop_more)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* rtl/core/downward_stack_block_allocator.sv */
`default_nettype none
// Downward stack block allocator: one request item in, one result item out, one
// item at a time. A new block or a lowest-block resize passes through the decide,
// lowest-block update, pop (freed records popped off the bottom), finish and
// output states; a refused new block, or a resize when fewer than two records
// exist and the address is not the lowest block, goes from decide to finish. A
// non-lowest lookup compares one record a cycle; a hit then shrinks and pops,
// while a refused growth or an unknown address goes to finish. A stalled result
// is held until taken. The user must make configuration writes only while no
// item is in flight; the block itself does not enforce this.
module downward_stack_block_allocator
    import dsba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int ALIGN_BYTES  = 4096,
    parameter int HEADER_BYTES = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [0:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,  // block_address[31:0], size[63:32]
    input  wire logic         s_tuser,  // func[0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,  // result_address, move_source, move_dest,
                                        // move_length, hidden_low
    output logic [1:0]        m_tuser   // status[1:0]
);
    dsba_cmd_t  cmd;
    dsba_stat_t stat;
    logic [1:0] set_status;
    logic [31:0] top_address, r_addr, r_msrc, r_mdst, r_mlen, r_hid;
    logic [1:0]  r_stat;
    logic        cfg_we;
    logic        fits;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == 1'b0);
    assign prdata = (paddr == 1'b0) ? top_address : '0;

    dsba_datapath #(
        .MAX_BLOCKS(MAX_BLOCKS), .ALIGN_BYTES(ALIGN_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .clk, .rst_n, .cfg_we, .cfg_data(pwdata), .top_address, .cmd, .stat, .fits,
        .in_func(s_tuser), .in_addr(s_tdata[31:0]), .in_size(s_tdata[63:32]),
        .res_address(r_addr), .res_status(r_stat), .res_msrc(r_msrc),
        .res_mdst(r_mdst), .res_mlen(r_mlen), .res_hidden(r_hid), .set_status
    );

    dsba_ctrl u_ctrl (
        .clk, .rst_n, .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .fits, .stat, .cmd, .set_status
    );

    assign m_tdata = {r_hid, r_mlen, r_mdst, r_msrc, r_addr};
    assign m_tuser = r_stat;
endmodule
`default_nettype wire
